// ===== hdl/bsoc_pkg.sv =====
// Shared types, constants and helper functions for the battery state-of-charge interpolator.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package bsoc_pkg;

  localparam int unsigned MAX_BREAKPOINTS = 6;
  localparam int unsigned VOLTAGE_BITS    = 16;
  localparam int unsigned PCT_BITS        = 7;
  localparam int unsigned BP_BITS         = VOLTAGE_BITS + PCT_BITS;
  localparam int unsigned COUNT_BITS      = 3;
  localparam int unsigned BP_IDX_BITS     = $clog2(MAX_BREAKPOINTS);
  localparam int unsigned CFG_IDX_BITS    = $clog2(MAX_BREAKPOINTS + 2);
  localparam int unsigned CFG_DATA_BITS   = BP_BITS;
  localparam int unsigned SOC_BITS        = 14;
  localparam int unsigned VSIG_BITS       = VOLTAGE_BITS + 2;
  localparam int unsigned NUM_BITS        = SOC_BITS + VOLTAGE_BITS;
  localparam int unsigned SUM_BITS        = NUM_BITS + 2;
  localparam int unsigned DIV_RADIX_BITS  = 2;
  localparam int unsigned DIV_STEPS       = NUM_BITS / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_BITS    = $clog2(DIV_STEPS);

  localparam int unsigned MIN_COUNT       = 2;
  localparam int unsigned CENTI_PER_PCT   = 100;
  localparam int unsigned CENTI_FULL      = 10000;
  localparam int unsigned PCT_FULL        = 100;

  localparam int unsigned BP0_RESET_VOLT  = 11000;
  localparam int unsigned BP1_RESET_VOLT  = 13000;

  localparam logic [COUNT_BITS-1:0]   COUNT_RESET = COUNT_BITS'(MIN_COUNT);

  localparam logic [CFG_IDX_BITS-1:0] REG_COUNT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DELTA   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_BP_BASE = CFG_IDX_BITS'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHG,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } bsoc_state_e;

  typedef struct packed {
    logic load;
    logic chg;
    logic scan;
    logic mul;
    logic div;
    logic sum;
    logic out_load;
  } bsoc_cmd_t;

  typedef struct packed {
    logic scan_final;
    logic scan_break;
    logic div_last;
    logic out_full;
  } bsoc_sts_t;

  function automatic logic [BP_BITS-1:0] bp_reset(input int unsigned i);
    logic [BP_BITS-1:0] val;
    val = '0;
    if (i == 0) begin
      val = BP_BITS'(BP0_RESET_VOLT);
    end else if (i == 1) begin
      val = BP_BITS'((PCT_FULL << VOLTAGE_BITS) | BP1_RESET_VOLT);
    end
    return val;
  endfunction

  function automatic logic [SOC_BITS-1:0] pct_to_centi(input logic [PCT_BITS-1:0] pct);
    logic [SOC_BITS-1:0] p;
    p = SOC_BITS'(pct) * SOC_BITS'(CENTI_PER_PCT);
    return (p > SOC_BITS'(CENTI_FULL)) ? SOC_BITS'(CENTI_FULL) : p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bsoc_div.sv =====
// Serial restoring divider, two quotient bits per cycle while step_i is high, unsigned operands.
// Depends on bsoc_pkg for operand widths and step count.
`default_nettype none

module bsoc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic                                step_i,
  input  wire logic [bsoc_pkg::NUM_BITS-1:0]       dividend_i,
  input  wire logic [bsoc_pkg::VOLTAGE_BITS-1:0]   divisor_i,
  output logic      [bsoc_pkg::NUM_BITS-1:0]       quotient_o,
  output logic                                     last_o
);

  logic [bsoc_pkg::VOLTAGE_BITS-1:0] rem_q, rem_d;
  logic [bsoc_pkg::NUM_BITS-1:0]     quo_q, quo_d;
  logic [bsoc_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic [bsoc_pkg::VOLTAGE_BITS:0]   ext;
  logic [bsoc_pkg::VOLTAGE_BITS:0]   diff;
  logic                              ge;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    ext   = '0;
    diff  = '0;
    ge    = 1'b0;
    for (int k = 0; k < bsoc_pkg::DIV_RADIX_BITS; k++) begin
      ext   = {rem_d, quo_d[bsoc_pkg::NUM_BITS-1]};
      diff  = ext - {1'b0, divisor_i};
      ge    = (ext >= {1'b0, divisor_i});
      rem_d = ge ? diff[bsoc_pkg::VOLTAGE_BITS-1:0] : ext[bsoc_pkg::VOLTAGE_BITS-1:0];
      quo_d = {quo_d[bsoc_pkg::NUM_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == bsoc_pkg::DIV_CNT_BITS'(bsoc_pkg::DIV_STEPS - 1));

endmodule

`default_nettype wire

// ===== hdl/bsoc_dp.sv =====
// Datapath: configuration registers, charge detection, breakpoint scan, product and result.
// Depends on bsoc_pkg and instantiates bsoc_div; driven by bsoc_ctrl commands.
`default_nettype none

module bsoc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire bsoc_pkg::bsoc_cmd_t                  cmd_i,
  output bsoc_pkg::bsoc_sts_t                       sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bsoc_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [bsoc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic [bsoc_pkg::VOLTAGE_BITS-1:0]    raw_voltage_mv_i,
  input  wire logic [bsoc_pkg::VOLTAGE_BITS-1:0]    smoothed_voltage_mv_i,
  input  wire logic                                 smoothed_valid_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic      [bsoc_pkg::SOC_BITS-1:0]        soc_centipercent_o,
  output logic                                      charging_o
);

  localparam int unsigned VB = bsoc_pkg::VOLTAGE_BITS;
  localparam int unsigned PB = bsoc_pkg::PCT_BITS;
  localparam int unsigned SB = bsoc_pkg::SOC_BITS;

  logic [bsoc_pkg::COUNT_BITS-1:0]   count_q;
  logic [VB-1:0]                     delta_q;
  logic [bsoc_pkg::BP_BITS-1:0]      bp_q [bsoc_pkg::MAX_BREAKPOINTS];
  logic [bsoc_pkg::CFG_IDX_BITS-1:0] bp_wr_off;

  logic [bsoc_pkg::BP_IDX_BITS-1:0]  last_idx;
  logic [bsoc_pkg::BP_IDX_BITS-1:0]  rd_idx;
  logic [bsoc_pkg::BP_BITS-1:0]      bp_rd;
  logic [VB-1:0]                     ve;
  logic [PB-1:0]                     pe;

  logic [VB-1:0]                     raw_q;
  logic [VB-1:0]                     smooth_q;
  logic                              valid_q;
  logic                              charging_q;
  logic                              chg_d;
  logic [VB-1:0]                     delta_sel;
  logic signed [bsoc_pkg::VSIG_BITS-1:0] v_q, v_d;

  logic [bsoc_pkg::BP_IDX_BITS-1:0]  idx_q;
  logic [PB-1:0]                     ps_q;
  logic [VB-1:0]                     vs_q;

  logic                              v_ge_ve;
  logic                              hit_zero;
  logic                              hit_full;
  logic                              brk;
  logic                              at_last;
  logic                              seg_flat;
  logic                              scan_final;
  logic [SB-1:0]                     scan_res;

  logic signed [PB:0]                dpct;
  logic [PB:0]                       dpct_abs;
  logic signed [bsoc_pkg::VSIG_BITS-1:0] dv;
  logic [bsoc_pkg::VSIG_BITS-1:0]    dv_abs;
  logic [SB-1:0]                     dpct100_q;
  logic [VB-1:0]                     dv_mag_q;
  logic [VB-1:0]                     den_q;
  logic                              neg_q;

  logic [bsoc_pkg::NUM_BITS-1:0]     prod;
  logic [bsoc_pkg::NUM_BITS-1:0]     quotient;
  logic                              div_last;

  logic [SB-1:0]                     ps100;
  logic signed [bsoc_pkg::SUM_BITS-1:0] base_s, quo_s, sum_s;
  logic [SB-1:0]                     sum_res;

  logic [SB-1:0]                     res_q;
  logic [SB-1:0]                     soc_q;
  logic                              chg_out_q;
  logic                              out_valid_q;

  // configuration registers
  assign bp_wr_off = cfg_index_i - bsoc_pkg::REG_BP_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= bsoc_pkg::COUNT_RESET;
      delta_q <= '0;
      for (int i = 0; i < bsoc_pkg::MAX_BREAKPOINTS; i++) begin
        bp_q[i] <= bsoc_pkg::bp_reset(i);
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == bsoc_pkg::REG_COUNT) begin
        count_q <= cfg_data_i[bsoc_pkg::COUNT_BITS-1:0];
      end else if (cfg_index_i == bsoc_pkg::REG_DELTA) begin
        delta_q <= cfg_data_i[VB-1:0];
      end else if (cfg_index_i >= bsoc_pkg::REG_BP_BASE &&
                   int'(bp_wr_off) < bsoc_pkg::MAX_BREAKPOINTS) begin
        bp_q[bp_wr_off[bsoc_pkg::BP_IDX_BITS-1:0]] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (count_q < bsoc_pkg::COUNT_BITS'(bsoc_pkg::MIN_COUNT)) begin
      last_idx = bsoc_pkg::BP_IDX_BITS'(bsoc_pkg::MIN_COUNT - 1);
    end else if (count_q > bsoc_pkg::COUNT_BITS'(bsoc_pkg::MAX_BREAKPOINTS)) begin
      last_idx = bsoc_pkg::BP_IDX_BITS'(bsoc_pkg::MAX_BREAKPOINTS - 1);
    end else begin
      last_idx = bsoc_pkg::BP_IDX_BITS'(count_q - 1'b1);
    end
  end

  // single breakpoint read port
  assign rd_idx = cmd_i.chg ? last_idx : idx_q;
  assign bp_rd  = bp_q[rd_idx];
  assign ve     = bp_rd[VB-1:0];
  assign pe     = bp_rd[bsoc_pkg::BP_BITS-1:VB];

  // input word and charge detection
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q    <= raw_voltage_mv_i;
      smooth_q <= smoothed_voltage_mv_i;
      valid_q  <= smoothed_valid_i;
    end
  end

  assign chg_d     = ({1'b0, raw_q, 1'b0} >= ({1'b0, ve, 1'b0} + {2'b00, delta_q}));
  assign delta_sel = chg_d ? delta_q : '0;
  assign v_d       = $signed({2'b00, smooth_q}) - $signed({2'b00, delta_sel});

  // scan step
  assign v_ge_ve  = (v_q >= $signed({2'b00, ve}));
  assign hit_zero = (pe == '0) && !v_ge_ve;
  assign hit_full = (pe == PB'(bsoc_pkg::PCT_FULL)) && v_ge_ve;
  assign brk      = !v_ge_ve;
  assign at_last  = (idx_q == last_idx);
  assign seg_flat = (ve <= vs_q);

  assign scan_final = !valid_q || hit_zero || hit_full || (brk && seg_flat) ||
                      (!brk && at_last);

  always_comb begin
    if (!valid_q || hit_zero) begin
      scan_res = '0;
    end else if (hit_full) begin
      scan_res = SB'(bsoc_pkg::CENTI_FULL);
    end else if (brk) begin
      scan_res = bsoc_pkg::pct_to_centi(ps_q);
    end else begin
      scan_res = bsoc_pkg::pct_to_centi(pe);
    end
  end

  assign dpct     = $signed({1'b0, pe}) - $signed({1'b0, ps_q});
  assign dpct_abs = dpct[PB] ? -dpct : dpct;
  assign dv       = v_q - $signed({2'b00, vs_q});
  assign dv_abs   = dv[bsoc_pkg::VSIG_BITS-1] ? -dv : dv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.chg) begin
      charging_q <= chg_d;
      v_q        <= v_d;
      idx_q      <= '0;
      ps_q       <= '0;
      vs_q       <= '0;
    end else if (cmd_i.scan) begin
      if (brk) begin
        dpct100_q <= SB'(dpct_abs[PB-1:0]) * SB'(bsoc_pkg::CENTI_PER_PCT);
        dv_mag_q  <= dv_abs[VB-1:0];
        den_q     <= ve - vs_q;
        neg_q     <= dpct[PB] ^ dv[bsoc_pkg::VSIG_BITS-1];
      end else begin
        ps_q  <= pe;
        vs_q  <= ve;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // interpolation
  assign prod = bsoc_pkg::NUM_BITS'(dpct100_q) * bsoc_pkg::NUM_BITS'(dv_mag_q);

  bsoc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.mul),
    .step_i     (cmd_i.div),
    .dividend_i (prod),
    .divisor_i  (den_q),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  assign ps100  = SB'(ps_q) * SB'(bsoc_pkg::CENTI_PER_PCT);
  assign base_s = $signed({{(bsoc_pkg::SUM_BITS - SB){1'b0}}, ps100});
  assign quo_s  = $signed({2'b00, quotient});
  assign sum_s  = neg_q ? (base_s - quo_s) : (base_s + quo_s);

  always_comb begin
    if (sum_s < 0) begin
      sum_res = '0;
    end else if (sum_s > $signed(bsoc_pkg::SUM_BITS'(bsoc_pkg::CENTI_FULL))) begin
      sum_res = SB'(bsoc_pkg::CENTI_FULL);
    end else begin
      sum_res = sum_s[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && scan_final) begin
      res_q <= scan_res;
    end else if (cmd_i.sum) begin
      res_q <= sum_res;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      soc_q     <= res_q;
      chg_out_q <= charging_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign soc_centipercent_o = soc_q;
  assign charging_o         = chg_out_q;

  assign sts_o.scan_final = scan_final;
  assign sts_o.scan_break = valid_q && brk && !hit_zero && !seg_flat;
  assign sts_o.div_last   = div_last;
  assign sts_o.out_full   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// ===== hdl/bsoc_ctrl.sv =====
// Controller state machine: sequences accept, charge check, scan, product, divide, sum and handoff.
// Depends on bsoc_pkg; talks to bsoc_dp through command and status structs.
`default_nettype none

module bsoc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bsoc_pkg::bsoc_sts_t  sts_i,
  output bsoc_pkg::bsoc_cmd_t       cmd_o
);

  bsoc_pkg::bsoc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsoc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsoc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bsoc_pkg::ST_CHG;
      end
      bsoc_pkg::ST_CHG: begin
        state_d = bsoc_pkg::ST_SCAN;
      end
      bsoc_pkg::ST_SCAN: begin
        if (sts_i.scan_final) begin
          state_d = bsoc_pkg::ST_DONE;
        end else if (sts_i.scan_break) begin
          state_d = bsoc_pkg::ST_MUL;
        end
      end
      bsoc_pkg::ST_MUL: begin
        state_d = bsoc_pkg::ST_DIV;
      end
      bsoc_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = bsoc_pkg::ST_SUM;
      end
      bsoc_pkg::ST_SUM: begin
        state_d = bsoc_pkg::ST_DONE;
      end
      bsoc_pkg::ST_DONE: begin
        if (!sts_i.out_full) state_d = bsoc_pkg::ST_IDLE;
      end
      default: begin
        state_d = bsoc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bsoc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bsoc_pkg::ST_CHG:  cmd_o.chg  = 1'b1;
      bsoc_pkg::ST_SCAN: cmd_o.scan = 1'b1;
      bsoc_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      bsoc_pkg::ST_DIV:  cmd_o.div  = 1'b1;
      bsoc_pkg::ST_SUM:  cmd_o.sum  = 1'b1;
      bsoc_pkg::ST_DONE: cmd_o.out_load = !sts_i.out_full;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/battery_soc_interpolator.sv =====
// Top level of the battery state-of-charge interpolator.
// Depends on bsoc_pkg; instantiates bsoc_ctrl and bsoc_dp.
//
// Takes one voltage word at a time and returns one state-of-charge word, in hundredths of a
// percent, plus the charging flag. A word whose result is settled by the breakpoint scan passes
// through the charge check and the scan; a word that falls inside a segment also passes through
// the product, the 2-bit-per-cycle divider and the final sum. The scan reads one breakpoint per
// cycle, and the result then moves into the output register once that register is free. A new
// word is taken once the previous one has moved into the output register, which holds the result
// until the consumer takes it. Configuration writes are taken at any time but must only be issued
// while no word is in flight.
`default_nettype none

module battery_soc_interpolator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bsoc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [bsoc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [bsoc_pkg::VOLTAGE_BITS-1:0]   raw_voltage_mv_i,
  input  wire logic [bsoc_pkg::VOLTAGE_BITS-1:0]   smoothed_voltage_mv_i,
  input  wire logic                                smoothed_valid_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [bsoc_pkg::SOC_BITS-1:0]       soc_centipercent_o,
  output logic                                     charging_o
);

  bsoc_pkg::bsoc_cmd_t cmd;
  bsoc_pkg::bsoc_sts_t sts;

  bsoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsoc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .raw_voltage_mv_i      (raw_voltage_mv_i),
    .smoothed_voltage_mv_i (smoothed_voltage_mv_i),
    .smoothed_valid_i      (smoothed_valid_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .soc_centipercent_o    (soc_centipercent_o),
    .charging_o            (charging_o)
  );

endmodule

`default_nettype wire
